>>> rtl/naps_pkg.sv
// Shared constants, types and register codes of the noise adaptive pixel stretch.
package naps_pkg;

  // Default sizes handed to the top level
  localparam int PIXEL_BITS_DEF = 16;
  localparam int MAX_PASSES_DEF = 5;

  // Internal fixed point: Q1.30 values, Q16 weights
  localparam int FRAC = 30;
  localparam logic [30:0] ONE30 = 31'h4000_0000;
  localparam logic [16:0] W_ONE = 17'h1_0000;
  localparam logic [30:0] LIFT_OFFS = 31'(ONE30 / 20);
  localparam logic [30:0] FAINT_MAX = 31'(ONE30 / 10);
  localparam logic [12:0] RECIP10 = 13'd6554;

  // Configuration register codes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BLACK     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PASSES    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGND   = 3'd5;

  // Reset values of the registers
  localparam int NOISE_RST     = 655;
  localparam int THRESHOLD_RST = 1280;
  localparam int STRENGTH_RST  = 768;
  localparam int PASSES_RST    = 1;
  localparam int BACKGND_RST   = 6554;

  // Settings each pass needs, in Q30, Q38 or Q8.8, plus a flag
  typedef struct packed {
    logic [29:0] n30;
    logic [42:0] nthr;
    logic        thr_zero;
    logic [11:0] s;
    logic [11:0] gden;
  } cfg_t;

  // Per item flags carried alongside the value
  typedef struct packed {
    logic black;
    logic bright;
  } flags_t;

endpackage

>>> rtl/naps_pass.sv
// One stretch pass: SNR weight, two power curves through log and exp, and the blend.
module naps_pass (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  naps_pkg::cfg_t    cfg,
  input  logic              act,
  input  logic              in_vld,
  input  logic [30:0]       in_r,
  input  naps_pkg::flags_t  in_flags,
  output logic              out_vld,
  output logic [30:0]       out_r,
  output naps_pkg::flags_t  out_flags
);

  localparam int NSQ    = 16;
  localparam int NQ     = 21;
  localparam int NEX    = 16;
  localparam int S_FIN  = 1 + NSQ;
  localparam int S_DIV0 = S_FIN + 1;
  localparam int S_EXP0 = S_DIV0 + NQ;
  localparam int S_SHF  = S_EXP0 + NEX;
  localparam int S_MUL  = S_SHF + 1;
  localparam int S_SUM  = S_MUL + 1;
  localparam int NS     = S_SUM + 1;

  typedef struct packed {
    logic [30:0]      r;
    logic             act;
    naps_pkg::flags_t flags;
    logic             zero;
    logic             one;
    logic [30:0]      m;
    logic [15:0]      fr;
    logic [4:0]       ip;
    logic [43:0]      wrem;
    logic             wfix;
    logic [15:0]      t;
    logic [15:0]      t2;
    logic [16:0]      w;
    logic [20:0]      el;
    logic [11:0]      rf;
    logic [11:0]      rg;
    logic [20:0]      ef;
    logic [20:0]      eg;
    logic [30:0]      xf;
    logic [30:0]      xg;
    logic [47:0]      pf;
    logic [47:0]      pg;
  } pst_t;

  // Integer square root, run only at elaboration for the exp table
  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v   = val;
    res = '0;
    bt  = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Q30 factor 2^(-2^-i) by repeated square roots of one half
  function automatic logic [30:0] root_entry(input int idx);
    logic [63:0] acc;
    acc = 64'd1 << 29;
    for (int j = 1; j <= 16; j++) begin
      if (j <= idx) acc = isqrt64(acc << naps_pkg::FRAC);
    end
    return acc[30:0];
  endfunction

  pst_t st  [NS];
  pst_t nx  [NS];
  logic vld [NS];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      if (k == 0) begin : g_entry
        // Classify the value, start the weight and normalize for the log
        always_comb begin
          logic [30:0] n2;
          logic [30:0] sig;
          logic [38:0] sig8;
          logic [4:0]  p;
          nx[k]       = '0;
          nx[k].r     = in_r;
          nx[k].act   = act && !in_flags.black;
          nx[k].flags = in_flags;
          nx[k].zero  = (in_r == '0);
          nx[k].one   = in_r[30];
          n2   = {cfg.n30, 1'b0};
          sig  = (in_r > n2) ? in_r - n2 : '0;
          sig8 = {sig, 8'd0};
          if (cfg.n30 == '0) begin
            nx[k].wfix = 1'b1;
            nx[k].w    = (sig != '0 || cfg.thr_zero) ? naps_pkg::W_ONE : '0;
          end else if ({4'd0, sig8} >= cfg.nthr) begin
            nx[k].wfix = 1'b1;
            nx[k].w    = naps_pkg::W_ONE;
          end else begin
            nx[k].wfix = 1'b0;
            nx[k].wrem = {5'd0, sig8};
          end
          p = 5'd29;
          for (int b = 0; b < 30; b++) begin
            if (in_r[b]) p = 5'(b);
          end
          nx[k].ip = 5'd30 - p;
          nx[k].m  = 31'({1'b0, in_r[29:0]} << nx[k].ip);
        end
      end else if (k <= NSQ) begin : g_log
        // Square the mantissa for one log bit, take one weight quotient bit
        always_comb begin
          logic [61:0] sq;
          logic [31:0] s32;
          logic [43:0] rem2;
          nx[k] = st[k-1];
          sq  = {31'd0, st[k-1].m} * {31'd0, st[k-1].m};
          s32 = sq[61:30];
          if (s32[31]) begin
            nx[k].m  = s32[31:1];
            nx[k].fr = {st[k-1].fr[14:0], 1'b1};
          end else begin
            nx[k].m  = s32[30:0];
            nx[k].fr = {st[k-1].fr[14:0], 1'b0};
          end
          rem2 = {st[k-1].wrem[42:0], 1'b0};
          if (rem2 >= {1'b0, cfg.nthr}) begin
            nx[k].wrem = rem2 - {1'b0, cfg.nthr};
            nx[k].t    = {st[k-1].t[14:0], 1'b1};
          end else begin
            nx[k].wrem = rem2;
            nx[k].t    = {st[k-1].t[14:0], 1'b0};
          end
        end
      end else if (k == S_FIN) begin : g_fin
        // Form the log, square the ratio, load the quotient and exp units
        always_comb begin
          logic [31:0] tt;
          logic [20:0] el;
          nx[k] = st[k-1];
          el = {st[k-1].ip, 16'd0} - {5'd0, st[k-1].fr};
          tt = {16'd0, st[k-1].t} * {16'd0, st[k-1].t};
          nx[k].el = el;
          nx[k].t2 = tt[31:16];
          nx[k].rf = {4'd0, el[20:13]};
          nx[k].rg = {4'd0, el[20:13]};
          nx[k].ef = '0;
          nx[k].eg = '0;
          nx[k].xf = naps_pkg::ONE30;
          nx[k].xg = naps_pkg::ONE30;
        end
      end else if (k < S_EXP0) begin : g_div
        // One exponent quotient bit for each curve; finish the weight first
        localparam int J = S_EXP0 - 1 - k;
        always_comb begin
          logic        nb;
          logic [12:0] rf2;
          logic [12:0] rg2;
          logic [17:0] f18;
          logic [33:0] wp;
          nx[k] = st[k-1];
          if (J >= 8) nb = st[k-1].el[J-8];
          else nb = 1'b0;
          rf2 = {st[k-1].rf, nb};
          rg2 = {st[k-1].rg, nb};
          if (rf2 >= {1'b0, cfg.s}) begin
            nx[k].rf = 12'(rf2 - {1'b0, cfg.s});
            nx[k].ef = {st[k-1].ef[19:0], 1'b1};
          end else begin
            nx[k].rf = rf2[11:0];
            nx[k].ef = {st[k-1].ef[19:0], 1'b0};
          end
          if (rg2 >= {1'b0, cfg.gden}) begin
            nx[k].rg = 12'(rg2 - {1'b0, cfg.gden});
            nx[k].eg = {st[k-1].eg[19:0], 1'b1};
          end else begin
            nx[k].rg = rg2[11:0];
            nx[k].eg = {st[k-1].eg[19:0], 1'b0};
          end
          f18 = 18'h3_0000 - {1'b0, st[k-1].t, 1'b0};
          wp  = {18'd0, st[k-1].t2} * {16'd0, f18};
          if (k == S_DIV0 && !st[k-1].wfix) nx[k].w = wp[32:16];
        end
      end else if (k < S_SHF) begin : g_exp
        // Multiply in the root factor for one fraction bit of each exponent
        localparam int I = k - S_EXP0 + 1;
        localparam logic [30:0] TAB = root_entry(I);
        always_comb begin
          logic [61:0] mf;
          logic [61:0] mg;
          nx[k] = st[k-1];
          mf = {31'd0, st[k-1].xf} * {31'd0, TAB};
          mg = {31'd0, st[k-1].xg} * {31'd0, TAB};
          if (st[k-1].ef[16-I]) nx[k].xf = mf[60:30];
          if (st[k-1].eg[16-I]) nx[k].xg = mg[60:30];
        end
      end else if (k == S_SHF) begin : g_shf
        // Apply the integer part of each exponent and the end values
        always_comb begin
          logic [4:0] kf;
          logic [4:0] kg;
          nx[k] = st[k-1];
          kf = st[k-1].ef[20:16];
          kg = st[k-1].eg[20:16];
          if (st[k-1].zero) begin
            nx[k].xf = '0;
            nx[k].xg = '0;
          end else if (st[k-1].one) begin
            nx[k].xf = naps_pkg::ONE30;
            nx[k].xg = naps_pkg::ONE30;
          end else begin
            nx[k].xf = (kf == 5'd31) ? '0 : st[k-1].xf >> kf;
            nx[k].xg = (kg == 5'd31) ? '0 : st[k-1].xg >> kg;
          end
        end
      end else if (k == S_MUL) begin : g_mul
        // Weight both curves
        always_comb begin
          nx[k] = st[k-1];
          nx[k].pf = {17'd0, st[k-1].xg} * {31'd0, naps_pkg::W_ONE - st[k-1].w};
          nx[k].pg = {17'd0, st[k-1].xf} * {31'd0, st[k-1].w};
        end
      end else begin : g_sum
        // Sum the blend, or hold the value when this pass is skipped
        always_comb begin
          logic [47:0] sum;
          nx[k] = st[k-1];
          sum = st[k-1].pf + st[k-1].pg;
          if (st[k-1].act) nx[k].r = sum[46:16];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) st[k] <= nx[k];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (adv) begin
          if (k == 0) vld[k] <= in_vld;
          else vld[k] <= vld[(k == 0) ? 0 : k-1];
        end
      end
    end
  endgenerate

  assign out_vld   = vld[NS-1];
  assign out_r     = st[NS-1].r;
  assign out_flags = st[NS-1].flags;

endmodule

>>> rtl/noise_adaptive_pixel_stretch.sv
// Top level of the noise adaptive pixel stretch: registers, rescale, passes and output.
//
//   channel  | signals                                   | moves
//   ---------+-------------------------------------------+------------------------
//   input    | in_valid, in_stall, pixel_in              | one pixel item
//   output   | out_valid, out_stall, pixel_out           | one stretched item
//   config   | cfg_write, cfg_index, cfg_data            | one register write
//
// One item per cycle while the output is not stalled. The pipeline holds the rescale
// divider (30 quotient stages) and, in each pass, 16 log squarings, 21 exponent quotient
// stages and 16 exp products in series.
// Reset is synchronous and clears the valid bits and the registers.
// A stall on the output while out_valid is high freezes the whole pipeline and raises in_stall.
module noise_adaptive_pixel_stretch #(
  parameter int PIXEL_BITS = naps_pkg::PIXEL_BITS_DEF,
  parameter int MAX_PASSES = naps_pkg::MAX_PASSES_DEF,
  localparam int CW = (PIXEL_BITS > 13) ? PIXEL_BITS : 13
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [PIXEL_BITS-1:0]          pixel_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [PIXEL_BITS-1:0]          pixel_out,
  input  logic                           cfg_write,
  input  logic [naps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CW-1:0]                  cfg_data
);

  localparam int TO30 = naps_pkg::FRAC - PIXEL_BITS;
  localparam int PW   = $clog2(MAX_PASSES + 1);
  localparam int NF   = 31;
  localparam logic [PIXEL_BITS-1:0] HALF = PIXEL_BITS'(1) << (PIXEL_BITS - 1);
  localparam logic [PIXEL_BITS:0]   PONE = (PIXEL_BITS + 1)'(1) << PIXEL_BITS;
  localparam logic [31:0] HALF_LSB = 32'(1) << (TO30 - 1);

  logic adv;

  // Registers
  logic [PIXEL_BITS-1:0] black_r;
  logic [PIXEL_BITS-1:0] noise_r;
  logic [12:0]           thr_r;
  logic [11:0]           str_r;
  logic [2:0]            pcnt_r;
  logic [PIXEL_BITS-1:0] bg_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      black_r <= '0;
      noise_r <= PIXEL_BITS'(naps_pkg::NOISE_RST);
      thr_r   <= 13'(naps_pkg::THRESHOLD_RST);
      str_r   <= 12'(naps_pkg::STRENGTH_RST);
      pcnt_r  <= 3'(naps_pkg::PASSES_RST);
      bg_r    <= PIXEL_BITS'(naps_pkg::BACKGND_RST);
    end else if (cfg_write) begin
      unique case (cfg_index)
        naps_pkg::REG_BLACK:     black_r <= cfg_data[PIXEL_BITS-1:0];
        naps_pkg::REG_NOISE:     noise_r <= cfg_data[PIXEL_BITS-1:0];
        naps_pkg::REG_THRESHOLD: thr_r   <= cfg_data[12:0];
        naps_pkg::REG_STRENGTH:  str_r   <= cfg_data[11:0];
        naps_pkg::REG_PASSES:    pcnt_r  <= cfg_data[2:0];
        naps_pkg::REG_BACKGND:   bg_r    <= cfg_data[PIXEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clip the black level to one half; the entry compare reads it directly
  logic [PIXEL_BITS-1:0] bp_w;
  assign bp_w = (black_r > HALF) ? HALF : black_r;

  // Derived settings, refreshed every cycle
  logic [PIXEL_BITS:0]   dd_r;
  logic [31:0]           n3_r;
  logic [30:0]           lift_m_r;
  logic [PW-1:0]         passes_r;
  naps_pkg::cfg_t        cfg_r;

  always_ff @(posedge clk) begin
    logic [29:0]           n30_c;
    logic [11:0]           s_c;
    logic [13:0]           ga;
    logic [26:0]           gp;
    n30_c = {noise_r, {TO30{1'b0}}};
    s_c   = (str_r < 12'd256) ? 12'd256 : str_r;
    ga    = 14'd3 * 14'(s_c - 12'd256);
    gp    = 27'(ga) * 27'(naps_pkg::RECIP10);
    dd_r  <= PONE - {1'b0, bp_w};
    n3_r  <= 32'({2'b0, n30_c}) + 32'({1'b0, n30_c, 1'b0});
    lift_m_r <= 31'({bg_r, {TO30{1'b0}}}) + naps_pkg::LIFT_OFFS;
    if (pcnt_r == 3'd0) passes_r <= PW'(1);
    else if (int'(pcnt_r) > MAX_PASSES) passes_r <= PW'(MAX_PASSES);
    else passes_r <= PW'(pcnt_r);
    cfg_r.n30      <= n30_c;
    cfg_r.nthr     <= 43'(thr_r) * 43'(n30_c);
    cfg_r.thr_zero <= (thr_r == '0);
    cfg_r.s        <= s_c;
    cfg_r.gden     <= 12'd256 + 12'(gp[26:16]);
  end

  // Advance everything unless a finished item is held by the output
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Rescale divider: x = (v - bp) / (1 - bp), one quotient bit a stage
  typedef struct packed {
    logic                zero;
    logic [PIXEL_BITS:0] rem;
    logic [29:0]         q;
  } fst_t;

  fst_t fs  [NF];
  fst_t fn  [NF];
  logic fv  [NF];

  genvar k;
  generate
    for (k = 0; k < NF; k++) begin : g_front
      if (k == 0) begin : g_load
        always_comb begin
          fn[k].zero = (pixel_in <= bp_w);
          fn[k].rem  = {1'b0, pixel_in - bp_w};
          fn[k].q    = '0;
        end
      end else begin : g_step
        always_comb begin
          logic [PIXEL_BITS+1:0] rem2;
          fn[k] = fs[k-1];
          rem2  = {fs[k-1].rem, 1'b0};
          if (rem2 >= {1'b0, dd_r}) begin
            fn[k].rem = (PIXEL_BITS + 1)'(rem2 - {1'b0, dd_r});
            fn[k].q   = {fs[k-1].q[28:0], 1'b1};
          end else begin
            fn[k].rem = rem2[PIXEL_BITS:0];
            fn[k].q   = {fs[k-1].q[28:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (adv) fs[k] <= fn[k];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          fv[k] <= 1'b0;
        end else if (adv) begin
          if (k == 0) fv[k] <= in_valid;
          else fv[k] <= fv[(k == 0) ? 0 : k-1];
        end
      end
    end
  endgenerate

  // Tag black and clearly bright items before the passes
  logic [30:0]      pr  [MAX_PASSES+1];
  logic             pv  [MAX_PASSES+1];
  naps_pkg::flags_t pfl [MAX_PASSES+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      pr[0]         <= {1'b0, fs[NF-1].q};
      pfl[0].black  <= fs[NF-1].zero;
      pfl[0].bright <= ({2'b0, fs[NF-1].q} > n3_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pv[0] <= 1'b0;
    else if (adv) pv[0] <= fv[NF-1];
  end

  // Chain of passes; a pass beyond the count holds the value
  genvar i;
  generate
    for (i = 0; i < MAX_PASSES; i++) begin : g_pass
      naps_pass u_pass (
        .clk       (clk),
        .rst       (rst),
        .adv       (adv),
        .cfg       (cfg_r),
        .act       (i < int'(passes_r)),
        .in_vld    (pv[i]),
        .in_r      (pr[i]),
        .in_flags  (pfl[i]),
        .out_vld   (pv[i+1]),
        .out_r     (pr[i+1]),
        .out_flags (pfl[i+1])
      );
    end
  endgenerate

  // Lift faint real signal toward the background target, clamp to one
  logic [30:0] lr;
  logic        lblack;
  logic        lv;

  always_ff @(posedge clk) begin
    logic [30:0] rl;
    logic [31:0] avg;
    rl  = pr[MAX_PASSES];
    avg = 32'(pr[MAX_PASSES]) + 32'(lift_m_r);
    if (rl <= naps_pkg::FAINT_MAX && pfl[MAX_PASSES].bright && rl < lift_m_r) begin
      rl = avg[31:1];
    end
    if (rl > naps_pkg::ONE30) rl = naps_pkg::ONE30;
    if (adv) begin
      lr     <= rl;
      lblack <= pfl[MAX_PASSES].black;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) lv <= 1'b0;
    else if (adv) lv <= pv[MAX_PASSES];
  end

  // Round to the pixel format and saturate; black gives zero
  always_ff @(posedge clk) begin
    logic [31:0] rnd;
    logic [31:0] o;
    rnd = 32'(lr) + HALF_LSB;
    o   = rnd >> TO30;
    if (adv) begin
      if (lblack) pixel_out <= '0;
      else if (o > 32'({PIXEL_BITS{1'b1}})) pixel_out <= '1;
      else pixel_out <= o[PIXEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= lv;
  end

endmodule

>>> rtl/naps_checker.sv
// Port level checks of the noise adaptive pixel stretch, bound to the top level.
module naps_checker #(
  parameter int PIXEL_BITS = naps_pkg::PIXEL_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [PIXEL_BITS-1:0] pixel_out
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("item shown right after reset");

  // Input is held back exactly when a finished item waits
  a_stall_link: assert property (@(posedge clk) in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the held output");

  // A held item stays and keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_out))
    else $error("held item changed or dropped");

endmodule

bind noise_adaptive_pixel_stretch naps_checker #(.PIXEL_BITS(PIXEL_BITS)) u_naps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .pixel_out (pixel_out)
);
